// ----- design/hes_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hes_pkg
// Shared types, constants and helpers of the Heston Euler path step block.
// ----------------------------------------------------------------------------
package hes_pkg;

  // Fixed-point layout of variance, rates and spot.
  localparam int FRAC_BITS  = 24;
  // Shift that turns a Q.F by Q0.32 product into the Q.2F square root input.
  localparam int SQRT_SHIFT = 32 - FRAC_BITS;
  // Fraction bits of the normal draws.
  localparam int DRAW_FRAC  = 20;
  // Fraction bits of the exponent constants and the series argument.
  localparam int EXP_FRAC   = 30;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Square root unit: input below 2^55, one result bit per cycle.
  localparam int SQ_W = 56;
  localparam logic [SQ_W-1:0] SQ_FIRST_BIT = SQ_W'(1) << 54;

  // Series divider: 64-bit dividend, eight quotient bits per cycle.
  localparam int DIV_W        = 64;
  localparam int DIV_PER_STEP = 8;

  localparam logic [MUL_B_W-1:0] LOG2E_Q30 = 33'd1549082005;
  localparam logic [MUL_B_W-1:0] LN2_Q30   = 33'd744261118;
  localparam logic [4:0]         TAYLOR_TERMS = 5'd20;
  localparam logic [60:0]        ONE_Q60 = 61'd1 << 60;
  localparam logic [47:0]        SPOT_MAX = '1;

  // Variance fix modes; the unused code behaves as full truncation.
  typedef enum logic [1:0] {
    MODE_REFLECT = 2'd0,
    MODE_PARTIAL = 2'd1,
    MODE_FULL    = 2'd2
  } fix_mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FIX_MODE         = 3'd0,
    REG_MEAN_REVERSION   = 3'd1,
    REG_LONG_RUN_VAR     = 3'd2,
    REG_VOL_OF_VAR       = 3'd3,
    REG_INTEREST_RATE    = 3'd4,
    REG_STEP_TIME        = 3'd5,
    REG_INITIAL_SPOT     = 3'd6,
    REG_INITIAL_VARIANCE = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  fix_mode;
    logic [31:0] mean_reversion_rate;
    logic [31:0] long_run_variance;
    logic [31:0] vol_of_variance;
    logic [31:0] interest_rate;
    logic [31:0] step_time;
    logic [47:0] initial_spot;
    logic [30:0] initial_variance;
  } cfg_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_KDT, ST_SDT, ST_SQ1L, ST_SQ1, ST_XI, ST_KD, ST_TZ, ST_VN,
    ST_ADT, ST_WDT, ST_SQ2L, ST_SQ2, ST_RZ, ST_EADD, ST_ELOG, ST_U, ST_G,
    ST_TINIT, ST_TLO, ST_THI, ST_DIVL, ST_DIV, ST_TACC,
    ST_SP0, ST_SP1, ST_SP2, ST_SP3, ST_SP4, ST_FIN
  } state_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_KDT, OP_SDT, OP_SQ_LOAD, OP_SQ_STEP, OP_XI, OP_KD,
    OP_TZ, OP_VN, OP_ADT, OP_WDT, OP_RZ, OP_EADD, OP_ELOG, OP_U, OP_G,
    OP_TINIT, OP_TLO, OP_THI, OP_DIV_LOAD, OP_DIV_STEP, OP_TACC,
    OP_SP0, OP_SP1, OP_SP2, OP_SP3, OP_SP4, OP_SPOT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sq_last;
    logic div_last;
    logic term_last;
  } status_t;

  // Product shifted right by sh, signed by neg, rounded toward minus infinity.
  function automatic logic signed [PROD_W:0] mulsh_floor(input logic [PROD_W-1:0] prod,
                                                        input logic [5:0] sh,
                                                        input logic neg);
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] mask;
    logic              rem_nz;
    logic [PROD_W:0]   qx;
    q      = prod >> sh;
    mask   = ~({PROD_W{1'b1}} << sh);
    rem_nz = |(prod & mask);
    qx     = {1'b0, q} + {{PROD_W{1'b0}}, (neg & rem_nz)};
    return neg ? -$signed(qx) : $signed(qx);
  endfunction

endpackage
`default_nettype wire

// ----- design/hes_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hes_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hes_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [47:0]      cfg_data,
  output hes_pkg::cfg_t         cfg
);
  import hes_pkg::*;

  // Register writes; every index is a defined register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fix_mode            <= MODE_FULL;
      cfg.mean_reversion_rate <= '0;
      cfg.long_run_variance   <= '0;
      cfg.vol_of_variance     <= '0;
      cfg.interest_rate       <= '0;
      cfg.step_time           <= '0;
      cfg.initial_spot        <= '0;
      cfg.initial_variance    <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FIX_MODE:         cfg.fix_mode            <= cfg_data[1:0];
        REG_MEAN_REVERSION:   cfg.mean_reversion_rate <= cfg_data[31:0];
        REG_LONG_RUN_VAR:     cfg.long_run_variance   <= cfg_data[31:0];
        REG_VOL_OF_VAR:       cfg.vol_of_variance     <= cfg_data[31:0];
        REG_INTEREST_RATE:    cfg.interest_rate       <= cfg_data[31:0];
        REG_STEP_TIME:        cfg.step_time           <= cfg_data[31:0];
        REG_INITIAL_SPOT:     cfg.initial_spot        <= cfg_data[47:0];
        REG_INITIAL_VARIANCE: cfg.initial_variance    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/hes_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hes_ctrl
// Sequencer that steps the datapath through one Euler step per item.
// ----------------------------------------------------------------------------
module hes_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire hes_pkg::status_t status,
  output hes_pkg::cmd_t         cmd
);
  import hes_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_load;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag; a new result loads once the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_KDT;
        end
      end
      ST_KDT:   begin cmd.op = OP_KDT;     state_next = ST_SDT;  end
      ST_SDT:   begin cmd.op = OP_SDT;     state_next = ST_SQ1L; end
      ST_SQ1L:  begin cmd.op = OP_SQ_LOAD; state_next = ST_SQ1;  end
      ST_SQ1: begin
        cmd.op = OP_SQ_STEP;
        if (status.sq_last) state_next = ST_XI;
      end
      ST_XI:    begin cmd.op = OP_XI;      state_next = ST_KD;   end
      ST_KD:    begin cmd.op = OP_KD;      state_next = ST_TZ;   end
      ST_TZ:    begin cmd.op = OP_TZ;      state_next = ST_VN;   end
      ST_VN:    begin cmd.op = OP_VN;      state_next = ST_ADT;  end
      ST_ADT:   begin cmd.op = OP_ADT;     state_next = ST_WDT;  end
      ST_WDT:   begin cmd.op = OP_WDT;     state_next = ST_SQ2L; end
      ST_SQ2L:  begin cmd.op = OP_SQ_LOAD; state_next = ST_SQ2;  end
      ST_SQ2: begin
        cmd.op = OP_SQ_STEP;
        if (status.sq_last) state_next = ST_RZ;
      end
      ST_RZ:    begin cmd.op = OP_RZ;      state_next = ST_EADD; end
      ST_EADD:  begin cmd.op = OP_EADD;    state_next = ST_ELOG; end
      ST_ELOG:  begin cmd.op = OP_ELOG;    state_next = ST_U;    end
      ST_U:     begin cmd.op = OP_U;       state_next = ST_G;    end
      ST_G:     begin cmd.op = OP_G;       state_next = ST_TINIT; end
      ST_TINIT: begin cmd.op = OP_TINIT;   state_next = ST_TLO;  end
      ST_TLO:   begin cmd.op = OP_TLO;     state_next = ST_THI;  end
      ST_THI:   begin cmd.op = OP_THI;     state_next = ST_DIVL; end
      ST_DIVL:  begin cmd.op = OP_DIV_LOAD; state_next = ST_DIV; end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) state_next = ST_TACC;
      end
      ST_TACC: begin
        cmd.op     = OP_TACC;
        state_next = status.term_last ? ST_SP0 : ST_TLO;
      end
      ST_SP0:   begin cmd.op = OP_SP0;     state_next = ST_SP1;  end
      ST_SP1:   begin cmd.op = OP_SP1;     state_next = ST_SP2;  end
      ST_SP2:   begin cmd.op = OP_SP2;     state_next = ST_SP3;  end
      ST_SP3:   begin cmd.op = OP_SP3;     state_next = ST_SP4;  end
      ST_SP4:   begin cmd.op = OP_SP4;     state_next = ST_FIN;  end
      ST_FIN: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.op     = OP_SPOT;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/hes_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hes_dp
// Datapath: shared multiplier, square root unit, series divider and the
// working registers of one Euler step.
// ----------------------------------------------------------------------------
module hes_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hes_pkg::cfg_t    cfg,
  input  wire hes_pkg::cmd_t    cmd,
  input  wire logic [47:0]      in_data,
  input  wire logic             in_start,
  output hes_pkg::status_t      status,
  output logic [47:0]           out_spot,
  output logic [31:0]           out_variance,
  output logic                  out_sat
);
  import hes_pkg::*;

  localparam logic signed [43:0] VAR_MAX = 44'sd2147483647;
  localparam logic signed [43:0] VAR_MIN = -44'sd2147483648;

  // Path state and latched draws.
  logic        [47:0]       prev_spot;
  logic signed [31:0]       prev_var;
  logic signed [23:0]       zs;
  logic signed [23:0]       zv;
  logic        [47:0]       spot_cur;
  logic signed [31:0]       v;

  // Working registers.
  logic [PROD_W-1:0]        p;
  logic [31:0]              kdt;
  logic [35:0]              t;
  logic signed [43:0]       accv;
  logic signed [31:0]       vn;
  logic                     sat;
  logic signed [35:0]       e;
  logic signed [41:0]       u;
  logic [29:0]              g;
  logic [60:0]              term;
  logic [60:0]              sum;
  logic [60:0]              plo;
  logic [4:0]               n;
  logic [109:0]             sacc;

  // Square root and divider registers.
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_r;
  logic [SQ_W-1:0]          sq_bit;
  logic [DIV_W-1:0]         dq;
  logic [5:0]               drem;
  logic [2:0]               dcnt;

  // Combinational terms.
  logic                     refl;
  logic                     partial;
  logic signed [32:0]       vx;
  logic signed [32:0]       v_abs;
  logic signed [32:0]       v_pos;
  logic signed [32:0]       b_term;
  logic signed [32:0]       x_term;
  logic [32:0]              s_var;
  logic signed [34:0]       d;
  logic [34:0]              d_mag;
  logic [24:0]              zv_mag;
  logic [24:0]              zs_mag;
  logic signed [32:0]       vnx;
  logic [32:0]              w;
  logic signed [33:0]       a_val;
  logic [33:0]              a_mag;
  logic [35:0]              e_mag;
  logic signed [11:0]       k;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [SQ_W-1:0]          sq_trial;
  logic signed [43:0]       vsum;
  logic [91:0]              tprod;
  logic [DIV_W-1:0]         dq_next;
  logic [5:0]               drem_next;
  logic signed [12:0]       sh;
  logic [109:0]             spot_shift;
  logic [47:0]              spot_res;
  logic                     spot_sat;

  // Variance fix selection.
  always_comb begin
    refl    = (cfg.fix_mode == MODE_REFLECT);
    partial = (cfg.fix_mode == MODE_PARTIAL);
    vx      = 33'(v);
    v_abs   = v[31] ? -vx : vx;
    v_pos   = v[31] ? 33'sd0 : vx;
    b_term  = refl ? v_abs : vx;
    s_var   = refl ? v_abs : v_pos;
    x_term  = refl ? v_abs : (partial ? vx : v_pos);
    d       = $signed({3'b000, cfg.long_run_variance}) - 35'(x_term);
    d_mag   = d[34] ? 35'(-d) : d;
    zv_mag  = zv[23] ? 25'(-25'(zv)) : 25'(zv);
    zs_mag  = zs[23] ? 25'(-25'(zs)) : 25'(zs);
    vnx     = 33'(vn);
    w       = refl ? (vn[31] ? 33'(-vnx) : vnx) : (vn[31] ? 33'd0 : vnx);
    a_val   = 34'(signed'(cfg.interest_rate)) - $signed({2'b00, w[32:1]});
    a_mag   = a_val[33] ? 34'(-a_val) : a_val;
    e_mag   = e[35] ? 36'(-e) : e;
    k       = u[41:30];
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_KDT:  begin mul_a = MUL_A_W'(cfg.mean_reversion_rate); mul_b = MUL_B_W'(cfg.step_time); end
      OP_SDT:  begin mul_a = MUL_A_W'(s_var);         mul_b = MUL_B_W'(cfg.step_time); end
      OP_XI:   begin mul_a = MUL_A_W'(cfg.vol_of_variance); mul_b = MUL_B_W'(sq_r); end
      OP_KD:   begin mul_a = MUL_A_W'(kdt);           mul_b = MUL_B_W'(d_mag); end
      OP_TZ:   begin mul_a = t;                       mul_b = MUL_B_W'(zv_mag); end
      OP_ADT:  begin mul_a = MUL_A_W'(a_mag);         mul_b = MUL_B_W'(cfg.step_time); end
      OP_WDT:  begin mul_a = MUL_A_W'(w);             mul_b = MUL_B_W'(cfg.step_time); end
      OP_RZ:   begin mul_a = MUL_A_W'(sq_r);          mul_b = MUL_B_W'(zs_mag); end
      OP_ELOG: begin mul_a = e_mag;                   mul_b = LOG2E_Q30; end
      OP_G:    begin mul_a = MUL_A_W'(u[29:0]);       mul_b = LN2_Q30; end
      OP_TLO:  begin mul_a = MUL_A_W'(term[30:0]);    mul_b = MUL_B_W'(g); end
      OP_THI:  begin mul_a = MUL_A_W'(term[60:31]);   mul_b = MUL_B_W'(g); end
      OP_SP0:  begin mul_a = MUL_A_W'(spot_cur[23:0]);  mul_b = MUL_B_W'(sum[30:0]); end
      OP_SP1:  begin mul_a = MUL_A_W'(spot_cur[23:0]);  mul_b = MUL_B_W'(sum[60:31]); end
      OP_SP2:  begin mul_a = MUL_A_W'(spot_cur[47:24]); mul_b = MUL_B_W'(sum[30:0]); end
      OP_SP3:  begin mul_a = MUL_A_W'(spot_cur[47:24]); mul_b = MUL_B_W'(sum[60:31]); end
      default: ;
    endcase
  end

  // Square root step, variance sum, series product and divider steps.
  always_comb begin
    logic [5:0] rm;
    logic [DIV_W-1:0] qq;
    sq_trial = sq_r + sq_bit;
    vsum     = accv + 44'(mulsh_floor(p, 6'(DRAW_FRAC), zv[23]));
    tprod    = ({31'd0, p[60:0]} << 31) + {31'd0, plo};
    rm = drem;
    qq = dq;
    for (int i = 0; i < DIV_PER_STEP; i++) begin
      rm = {rm[4:0], qq[DIV_W-1]};
      qq = {qq[DIV_W-2:0], 1'b0};
      if (rm >= {1'b0, n}) begin
        rm    = rm - {1'b0, n};
        qq[0] = 1'b1;
      end
    end
    dq_next   = qq;
    drem_next = rm;
  end

  // Final scaling of the spot by 2^k, with saturation.
  always_comb begin
    sh         = 13'sd60 - 13'(k);
    spot_shift = sacc >> sh[6:0];
    spot_res   = spot_shift[47:0];
    spot_sat   = 1'b0;
    if (spot_cur == '0) begin
      spot_res = '0;
    end else if (sh < 0) begin
      spot_res = SPOT_MAX;
      spot_sat = 1'b1;
    end else if (sh > 13'sd127) begin
      spot_res = '0;
    end else if (|spot_shift[109:48]) begin
      spot_res = SPOT_MAX;
      spot_sat = 1'b1;
    end
  end

  assign status.sq_last   = sq_bit[0];
  assign status.div_last  = (dcnt == 3'd7);
  assign status.term_last = (n == TAYLOR_TERMS);

  // Registered product of the shared multiplier.
  always_ff @(posedge clk) begin
    p <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Path state: cleared by reset, updated at the end of each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_spot <= '0;
      prev_var  <= '0;
    end else if (cmd.op == OP_SPOT) begin
      prev_spot <= spot_res;
      prev_var  <= vn;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        zs <= in_data[23:0];
        zv <= in_data[47:24];
        if (in_start) begin
          spot_cur <= cfg.initial_spot;
          v        <= {1'b0, cfg.initial_variance};
        end else begin
          spot_cur <= prev_spot;
          v        <= prev_var;
        end
      end
      OP_SDT: kdt <= p[63:32];
      OP_SQ_LOAD: begin
        sq_x   <= SQ_W'(p >> SQRT_SHIFT);
        sq_r   <= '0;
        sq_bit <= SQ_FIRST_BIT;
      end
      OP_SQ_STEP: begin
        if (sq_x >= sq_trial) begin
          sq_x <= sq_x - sq_trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_KD: t <= 36'(p >> FRAC_BITS);
      OP_TZ: accv <= 44'(b_term) + 44'(mulsh_floor(p, 6'(FRAC_BITS), d[34]));
      OP_VN: begin
        if (vsum > VAR_MAX) begin
          vn  <= 32'(VAR_MAX);
          sat <= 1'b1;
        end else if (vsum < VAR_MIN) begin
          vn  <= 32'(VAR_MIN);
          sat <= 1'b1;
        end else begin
          vn  <= 32'(vsum);
          sat <= 1'b0;
        end
      end
      OP_WDT:  e <= 36'(mulsh_floor(p, 6'd32, a_val[33]));
      OP_EADD: e <= e + 36'(mulsh_floor(p, 6'(DRAW_FRAC), zs[23]));
      OP_U:    u <= 42'(mulsh_floor(p, 6'(FRAC_BITS), e[35]));
      OP_TINIT: begin
        g    <= p[59:30];
        term <= ONE_Q60;
        sum  <= ONE_Q60;
        n    <= 5'd1;
      end
      OP_THI: plo <= p[60:0];
      OP_DIV_LOAD: begin
        dq   <= DIV_W'(tprod >> EXP_FRAC);
        drem <= '0;
        dcnt <= '0;
      end
      OP_DIV_STEP: begin
        dq   <= dq_next;
        drem <= drem_next;
        dcnt <= dcnt + 3'd1;
      end
      OP_TACC: begin
        term <= dq[60:0];
        sum  <= sum + dq[60:0];
        n    <= n + 5'd1;
      end
      OP_SP1: sacc <= 110'(p);
      OP_SP2: sacc <= sacc + (110'(p) << 31);
      OP_SP3: sacc <= sacc + (110'(p) << 24);
      OP_SP4: sacc <= sacc + (110'(p) << 55);
      OP_SPOT: begin
        out_spot     <= spot_res;
        out_variance <= vn;
        out_sat      <= sat | spot_sat;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/heston_euler_path_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// heston_euler_path_step
// One Euler step of a Heston stochastic-volatility path per input transfer.
// ----------------------------------------------------------------------------
// Each accepted pair of normal draws produces one result, and the next item can
// be accepted in the same cycle that the result becomes valid. Two square root
// passes and an exponential series that adds 20 terms to its leading one, each
// term taking two multiplier passes, a divider load, the divider steps and an
// accumulate, dominate the step, all sharing one registered multiplier. The
// block takes one item at a time; the next item is accepted once the step
// finishes, and a finished result may wait in the output register while the
// next step runs. Configure the registers while the block is idle.
module heston_euler_path_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // spot_draw [23:0], variance_draw [47:24]
  input  wire logic [47:0] s_axis_tdata,
  // path_start [0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_spot [47:0], next_variance [79:48]
  output logic [79:0]      m_axis_tdata,
  // saturated [0]
  output logic [0:0]       m_axis_tuser
);
  import hes_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  status_t     status;
  logic [47:0] out_spot;
  logic [31:0] out_variance;
  logic        out_sat;

  hes_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  hes_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .in_data      (s_axis_tdata),
    .in_start     (s_axis_tuser[0]),
    .status       (status),
    .out_spot     (out_spot),
    .out_variance (out_variance),
    .out_sat      (out_sat)
  );

  assign m_axis_tdata = {out_variance, out_spot};
  assign m_axis_tuser = out_sat;

`ifndef NO_ASSERTIONS
  // An accepted transfer keeps the input side closed while the step runs.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again during a step");

  // A new result appears only at the end of a step, never from idle.
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised without a running step");
`endif

endmodule
`default_nettype wire
